// File: src/thac_pkg.sv
package thac_pkg;

  // TCP flag bit positions
  localparam int unsigned FlFin = 0;
  localparam int unsigned FlSyn = 1;
  localparam int unsigned FlRst = 2;
  localparam int unsigned FlPsh = 3;
  localparam int unsigned FlAck = 4;

  // Flag masks of the odd-combination rules
  localparam logic [7:0] FLAGS_PSH_ONLY    = 8'h08;
  localparam logic [7:0] MASK_SYN_URG      = 8'd34;
  localparam logic [7:0] MASK_FIN_URG      = 8'd33;
  localparam logic [7:0] MASK_RST_URG      = 8'd36;
  localparam logic [7:0] FLAGS_NONE        = 8'h00;
  localparam logic [7:0] MASK_SYN_FIN      = 8'h03;
  localparam logic [7:0] MASK_RST_FIN      = 8'h05;
  localparam logic [7:0] MASK_RST_SYN      = 8'h06;
  localparam logic [7:0] MASK_FIN_PSH_URG  = 8'd41;
  localparam logic [7:0] MASK_SFPU         = 8'd43;
  localparam logic [7:0] MASK_SYN_ECE_CWR  = 8'd194;

  // Special window values
  localparam logic [15:0] WIN_ACK_PROBE    = 16'd1024;
  localparam logic [15:0] WIN_SYN_NODF     = 16'd31337;
  localparam logic [15:0] WIN_SYN_DF       = 16'd32768;

  localparam logic [15:0] OPEN_PORT_RESET  = 16'd80;

  // ICMP message types
  localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;

  // Packet kind
  localparam logic OP_TCP  = 1'b0;
  localparam logic OP_ICMP = 1'b1;

  // Probe codes reported on tcp_probe
  typedef enum logic [3:0] {
    PROBE_NONE         = 4'd0,
    PROBE_PSH_ONLY     = 4'd1,
    PROBE_SYN_URG      = 4'd2,
    PROBE_FIN_URG      = 4'd3,
    PROBE_RST_URG      = 4'd4,
    PROBE_NULL         = 4'd5,
    PROBE_SYN_FIN      = 4'd6,
    PROBE_RST_FIN      = 4'd7,
    PROBE_RST_SYN      = 4'd8,
    PROBE_ACK_WIN      = 4'd9,
    PROBE_SYN_NODF     = 4'd10,
    PROBE_SYN_DF       = 4'd11,
    PROBE_FIN_PSH_URG  = 4'd12,
    PROBE_SFPU         = 4'd13,
    PROBE_SYN_ECE_CWR  = 4'd14
  } probe_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  flag_byte;
    logic        dont_fragment;
    logic [15:0] window_size;
    logic [15:0] dest_port;
    logic [7:0]  icmp_kind;
    logic [7:0]  icmp_subcode;
  } hdr_t;

  typedef struct packed {
    probe_t tcp_probe;
    logic   echo_bad_code;
    logic   reserved_type;
  } result_t;

endpackage

// File: src/thac_classify.sv
module thac_classify import thac_pkg::*; (
  input  hdr_t        hdr,
  input  logic [15:0] open_port,
  output result_t     res
);

  logic   closed;
  logic   df;
  probe_t probe;
  logic [7:0] f;

  assign f      = hdr.flag_byte;
  assign df     = hdr.dont_fragment;
  assign closed = hdr.dest_port != open_port;

  // first matching rule wins
  always_comb begin
    if (f == FLAGS_PSH_ONLY) begin
      probe = PROBE_PSH_ONLY;
    end else if ((f & MASK_SYN_URG) == MASK_SYN_URG) begin
      probe = PROBE_SYN_URG;
    end else if ((f & MASK_FIN_URG) == MASK_FIN_URG) begin
      probe = PROBE_FIN_URG;
    end else if ((f & MASK_RST_URG) == MASK_RST_URG) begin
      probe = PROBE_RST_URG;
    end else if (f == FLAGS_NONE) begin
      probe = PROBE_NULL;
    end else if ((f & MASK_SYN_FIN) == MASK_SYN_FIN) begin
      probe = PROBE_SYN_FIN;
    end else if ((f & MASK_RST_FIN) == MASK_RST_FIN) begin
      probe = PROBE_RST_FIN;
    end else if ((f & MASK_RST_SYN) == MASK_RST_SYN) begin
      probe = PROBE_RST_SYN;
    end else if (f[FlAck] && df && hdr.window_size == WIN_ACK_PROBE) begin
      probe = PROBE_ACK_WIN;
    end else if (f[FlSyn] && !df && hdr.window_size == WIN_SYN_NODF && closed) begin
      probe = PROBE_SYN_NODF;
    end else if (f[FlSyn] && df && hdr.window_size == WIN_SYN_DF && closed) begin
      probe = PROBE_SYN_DF;
    end else if ((f & MASK_FIN_PSH_URG) == MASK_FIN_PSH_URG) begin
      probe = PROBE_FIN_PSH_URG;
    end else if ((f & MASK_SFPU) == MASK_SFPU) begin
      probe = PROBE_SFPU;
    end else if ((f & MASK_SYN_ECE_CWR) == MASK_SYN_ECE_CWR) begin
      probe = PROBE_SYN_ECE_CWR;
    end else begin
      probe = PROBE_NONE;
    end
  end

  always_comb begin
    res = '0;
    if (hdr.op == OP_TCP) begin
      res.tcp_probe = probe;
    end else begin
      res.echo_bad_code = (hdr.icmp_kind == ICMP_ECHO_REQUEST) && (hdr.icmp_subcode != 8'd0);
      res.reserved_type = hdr.icmp_kind inside {8'd1, 8'd2, 8'd7, [8'd19:8'd29], [8'd42:8'd255]};
    end
  end

endmodule

// File: src/tcp_icmp_header_anomaly_classifier.sv
// Classifies one packet header per beat. A TCP segment gets the number of the
// first matching fingerprint-probe rule on tcp_probe (0 when none matches;
// rule 13 is always shadowed by rule 12); an ICMP message gets two flags,
// echo_bad_code and reserved_type, and tcp_probe reads 0. A header beat is
// captured in an input register, classified by a shallow priority match and
// held in a result register, so the block takes one beat every cycle while
// results are taken. in_ready follows out_ready within the same cycle, so
// both registers keep moving as long as results are taken. open_port resets
// to 80 and is written through cfg_we/cfg_wdata; the user must write it
// only while no beat is in flight, and the block does not enforce this.
module tcp_icmp_header_anomaly_classifier import thac_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  // header channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [7:0]  in_flag_byte,
  input  logic        in_dont_fragment,
  input  logic [15:0] in_window_size,
  input  logic [15:0] in_dest_port,
  input  logic [7:0]  in_icmp_kind,
  input  logic [7:0]  in_icmp_subcode,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_tcp_probe,
  output logic        out_echo_bad_code,
  output logic        out_reserved_type
);

  logic [15:0] open_port_q_r;
  logic        s1_valid_r;
  logic        s1_valid_nxt;
  hdr_t        s1_hdr_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  result_t     out_res_r;
  result_t     res;
  logic        s1_adv;

  // Advance the input register into the result register when the result
  // slot is empty or its beat is being taken.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;

  assign s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  thac_classify u_classify (
    .hdr       (s1_hdr_r),
    .open_port (open_port_q_r),
    .res       (res)
  );

  // Control state and the configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      open_port_q_r <= OPEN_PORT_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        open_port_q_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: capture a header beat, hold a stalled result
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_hdr_r.op            <= in_op;
      s1_hdr_r.flag_byte     <= in_flag_byte;
      s1_hdr_r.dont_fragment <= in_dont_fragment;
      s1_hdr_r.window_size   <= in_window_size;
      s1_hdr_r.dest_port     <= in_dest_port;
      s1_hdr_r.icmp_kind     <= in_icmp_kind;
      s1_hdr_r.icmp_subcode  <= in_icmp_subcode;
    end
    if (s1_adv && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tcp_probe     = out_res_r.tcp_probe;
  assign out_echo_bad_code = out_res_r.echo_bad_code;
  assign out_reserved_type = out_res_r.reserved_type;

endmodule

// File: src/thac_checker.sv
module thac_checker import thac_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_tcp_probe,
  input logic        out_echo_bad_code,
  input logic        out_reserved_type
);

  // Hold a stalled result beat
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tcp_probe)
      && $stable(out_echo_bad_code) && $stable(out_reserved_type))
    else $error("result beat changed while stalled");

  // Rule 13 is shadowed and codes stop at 14
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tcp_probe != PROBE_SFPU && out_tcp_probe != 4'd15)
    else $error("impossible probe code");

  // A TCP result carries no ICMP flags
  a_kind_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tcp_probe != PROBE_NONE |-> !out_echo_bad_code && !out_reserved_type)
    else $error("probe and ICMP flags together");

  // Echo request type is never reserved
  a_echo_not_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_bad_code |-> !out_reserved_type)
    else $error("echo flagged as reserved type");

  // Drop any result during reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind tcp_icmp_header_anomaly_classifier thac_checker u_thac_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_tcp_probe     (out_tcp_probe),
  .out_echo_bad_code (out_echo_bad_code),
  .out_reserved_type (out_reserved_type)
);
